### design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  localparam int unsigned PrefixBytesDef = 4;
  localparam int unsigned CntW           = 2;
  localparam int unsigned ShiftW         = 24;
  localparam int unsigned LenW           = 32;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned StatusW        = 2;

  localparam logic [LenW-1:0] MaxLenReset = 32'd65536;

  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [StatusW-1:0] STATUS_PAYLOAD  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_ERR_ZERO = 2'd1;
  localparam logic [StatusW-1:0] STATUS_ERR_LONG = 2'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_ERR_ZERO,
    KIND_ERR_LONG
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data;
    logic               last;
  } item_t;

endpackage

`default_nettype wire

### design/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front
// Byte parser: gathers the length prefix, tracks payload and error state,
// classifies every byte and pushes result items into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_front
  import lpd_pkg::*;
#(
  parameter int unsigned PREFIX_BYTES = PrefixBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             in_action_i,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [LenW-1:0]  cfg_data_i,
  output logic                  push_o,
  output item_t                 push_item_o,
  input  wire logic             full_i
);

  localparam logic [CntW-1:0] CntLast = CntW'(PREFIX_BYTES - 1);

  logic [LenW-1:0]   max_len_q, max_len_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              in_pay_q, in_pay_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic              drop_q, drop_d;
  logic              acc;
  logic [LenW-1:0]   len;

  assign in_ready_o = ~full_i;
  assign acc        = in_valid_i & in_ready_o;
  assign len        = {shift_q, in_byte_i};
  assign max_len_d  = cfg_valid_i ? cfg_data_i : max_len_q;

  always_comb begin
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    in_pay_d    = in_pay_q;
    rem_d       = rem_q;
    drop_d      = drop_q;
    push_o      = 1'b0;
    push_item_o = '{kind: KIND_PAYLOAD, data: '0, last: 1'b0};
    if (acc) begin
      if (in_action_i == ACT_RESTART) begin
        shift_d  = '0;
        cnt_d    = '0;
        in_pay_d = 1'b0;
        rem_d    = '0;
        drop_d   = 1'b0;
      end else if (!drop_q) begin
        if (in_pay_q) begin
          push_o           = 1'b1;
          push_item_o.data = in_byte_i;
          push_item_o.last = (rem_q <= LenW'(1));
          if (rem_q <= LenW'(1)) begin
            rem_d    = '0;
            in_pay_d = 1'b0;
          end else begin
            rem_d = rem_q - LenW'(1);
          end
        end else if (cnt_q != CntLast) begin
          shift_d = {shift_q[ShiftW-ByteW-1:0], in_byte_i};
          cnt_d   = cnt_q + CntW'(1);
        end else begin
          shift_d = '0;
          cnt_d   = '0;
          if (len == '0) begin
            push_o           = 1'b1;
            push_item_o.kind = KIND_ERR_ZERO;
            drop_d           = 1'b1;
          end else if (len > max_len_q) begin
            push_o           = 1'b1;
            push_item_o.kind = KIND_ERR_LONG;
            drop_d           = 1'b1;
          end else begin
            rem_d    = len;
            in_pay_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      shift_q   <= '0;
      cnt_q     <= '0;
      in_pay_q  <= 1'b0;
      rem_q     <= '0;
      drop_q    <= 1'b0;
    end else begin
      max_len_q <= max_len_d;
      shift_q   <= shift_d;
      cnt_q     <= cnt_d;
      in_pay_q  <= in_pay_d;
      rem_q     <= rem_d;
      drop_q    <= drop_d;
    end
  end

endmodule

`default_nettype wire

### design/lpd_queue.sv
// ----------------------------------------------------------------------------
// lpd_queue
// Two-entry queue of classified items between parser and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_queue
  import lpd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      push_item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      head_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o   = (cnt_q == 2'd2);
  assign valid_o  = (cnt_q != 2'd0);
  assign head_o   = mem_q[rd_ptr_q];
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & valid_o;
  assign wr_ptr_d = wr_ptr_q ^ do_push;
  assign rd_ptr_d = rd_ptr_q ^ do_pop;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/lpd_back.sv
// ----------------------------------------------------------------------------
// lpd_back
// Output stage: formats queued items into status, byte and last flag and
// holds them in a register until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_back
  import lpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  item_t                   q_head_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      out_status_o,
  output logic [ByteW-1:0]        out_byte_o,
  output logic                    out_last_o
);

  logic               valid_q, valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic               last_q, last_d;

  assign q_pop_o = q_valid_i & (~valid_q | out_ready_i);
  assign valid_d = q_pop_o | (valid_q & ~out_ready_i);

  always_comb begin
    status_d = status_q;
    byte_d   = byte_q;
    last_d   = last_q;
    if (q_pop_o) begin
      case (q_head_i.kind)
        KIND_PAYLOAD: begin
          status_d = STATUS_PAYLOAD;
          byte_d   = q_head_i.data;
          last_d   = q_head_i.last;
        end
        KIND_ERR_ZERO: begin
          status_d = STATUS_ERR_ZERO;
          byte_d   = '0;
          last_d   = 1'b0;
        end
        KIND_ERR_LONG: begin
          status_d = STATUS_ERR_LONG;
          byte_d   = '0;
          last_d   = 1'b0;
        end
        default: begin
          status_d = STATUS_ERR_LONG;
          byte_d   = '0;
          last_d   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_status_o = status_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;

endmodule

`default_nettype wire

### design/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a byte stream into frames announced by a 4-byte big-endian length.
//
// Input stream: one transfer per byte, tuser[0] = 1 restarts the connection
// (all parser state and any error cleared, byte ignored, no output).
// Output stream: tuser = status (0 payload, 1 zero length, 2 length too
// large), tdata = payload byte (zero on errors), tlast on the final byte.
// After an error every byte is dropped until a restart.
// cfg writes max_length, always ready; user writes only when idle (unchecked).
// Throughput: one byte per cycle sustained while tready stays high; the
// parser registers update once per byte, the output register every cycle.
// Result path: the parser writes an item into the queue when its byte is
// taken, and the queue moves it into the output register once that
// register is free or being taken by the receiver.
// Receiver stall: results wait in the output register and a two-entry
// queue; the input drops tready only when the queue is full.
// Reset: parser idle expecting a prefix, queue empty, max_length = 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_deframer_core
  import lpd_pkg::*;
#(
  parameter int unsigned PREFIX_BYTES = PrefixBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [ByteW-1:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic               s_axis_tuser_i,   // [0] action
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [ByteW-1:0]        m_axis_tdata_o,   // [7:0] out_byte
  output logic [StatusW-1:0]      m_axis_tuser_o,   // [1:0] status
  output logic                    m_axis_tlast_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LenW-1:0]    cfg_data_i        // [31:0] max_length
);

  logic  push, full, pop, q_valid;
  item_t push_item, head;

  assign cfg_ready_o = 1'b1;

  lpd_front #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  lpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  lpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
